>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker RTL.
// Both forms sample on aclk; the first is muted while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PLC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("plc assertion failed");

`define PLC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("plc assertion failed");

`else

`define PLC_ASSERT(lbl, prop)

`define PLC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/core/plc_pkg.sv
`default_nettype none

package plc_pkg;

    localparam int MAX_WORD_BITS = 32;
    localparam int CNT_W         = $clog2(MAX_WORD_BITS + 1);
    localparam int HIST_W        = 32;
    localparam int TOTAL_W       = 64;
    localparam int LOCKS_W       = 32;
    localparam int THR_W         = 32;
    localparam int ORDER_W       = 6;

    // LFSR bits evaluated per cycle in the back end
    localparam int CHUNK_BITS    = 8;
    localparam int CHUNK_CNT_W   = $clog2(CHUNK_BITS + 1);

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int REG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [THR_W-1:0]   LOCK_THR_RST   = 32'd2048;
    localparam logic [THR_W-1:0]   UNLOCK_THR_RST = 32'd128;
    localparam logic [HIST_W-1:0]  TAP_MASK_RST   = 32'd96;
    localparam logic [ORDER_W-1:0] POLY_ORDER_RST = 6'd7;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LOCK_THR   = 3'd0,
        REG_UNLOCK_THR = 3'd1,
        REG_TAP_MASK   = 3'd2,
        REG_POLY_ORDER = 3'd3,
        REG_INVERT     = 3'd4
    } reg_index_t;

    typedef enum logic {
        CMD_CHECK   = 1'b0,
        CMD_RESTART = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        PH_SEED    = 2'd0,
        PH_LOCKING = 2'd1,
        PH_LOCKED  = 2'd2
    } phase_t;

    typedef struct packed {
        logic                     mode;
        logic [MAX_WORD_BITS-1:0] data_word;
        logic [CNT_W-1:0]         bit_count;
    } in_t;

    typedef struct packed {
        logic               locked;
        logic               seeding;
        logic [TOTAL_W-1:0] total_bits;
        logic [TOTAL_W-1:0] error_bits;
        logic [LOCKS_W-1:0] lock_events;
        logic [CNT_W-1:0]   word_errors;
    } out_t;

    typedef struct packed {
        logic [THR_W-1:0]   lock_threshold;
        logic [THR_W-1:0]   unlock_threshold;
        logic [HIST_W-1:0]  tap_mask;
        logic [ORDER_W-1:0] poly_order;
        logic               invert_output;
    } cfg_t;

    // classified word: count saturated, unused bits cleared
    typedef struct packed {
        cmd_t                     cmd;
        logic [MAX_WORD_BITS-1:0] word;
        logic [CNT_W-1:0]         count;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic [HIST_W-1:0]      hist;
        logic [CHUNK_CNT_W-1:0] errs;
    } chunk_res_t;

    // Runs up to CHUNK_BITS steps of the Fibonacci LFSR. bits is left aligned:
    // bit CHUNK_BITS-1 is the oldest received bit.
    function automatic chunk_res_t lfsr_chunk(
        input logic [HIST_W-1:0]      hist,
        input logic [HIST_W-1:0]      taps,
        input logic                   inv,
        input logic [CHUNK_BITS-1:0]  bits,
        input logic [CHUNK_CNT_W-1:0] nbits
    );
        chunk_res_t             r;
        logic [HIST_W-1:0]      h;
        logic                   e;
        logic [CHUNK_CNT_W-1:0] errs;
        h    = hist;
        errs = '0;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            e = (^(h & taps)) ^ inv;
            if (CHUNK_CNT_W'(i) < nbits) begin
                h    = {h[HIST_W-2:0], e};
                errs = errs + CHUNK_CNT_W'(bits[CHUNK_BITS-1-i] ^ e);
            end
        end
        r.hist = h;
        r.errs = errs;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/plc_front.sv
`default_nettype none
`include "assert_macros.svh"

module plc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire plc_pkg::in_t      s_data,
    output plc_pkg::q_head_t       q_head,
    input  wire logic              q_pop
);

    plc_pkg::item_t                  q_mem [plc_pkg::QUEUE_DEPTH];
    plc_pkg::item_t                  item_in;
    logic [plc_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [plc_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [plc_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic [plc_pkg::CNT_W-1:0]       n_sat;
    logic [plc_pkg::MAX_WORD_BITS:0] keep_mask;
    logic                            push;

    assign s_ready = (cnt_reg != plc_pkg::QCNT_W'(plc_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;

    // classify: restart vs data, clamp count, drop unused bits
    always_comb begin
        n_sat = (s_data.bit_count > plc_pkg::CNT_W'(plc_pkg::MAX_WORD_BITS))
              ? plc_pkg::CNT_W'(plc_pkg::MAX_WORD_BITS) : s_data.bit_count;
        keep_mask    = ((plc_pkg::MAX_WORD_BITS + 1)'(1) << n_sat)
                     - (plc_pkg::MAX_WORD_BITS + 1)'(1);
        item_in.cmd  = s_data.mode ? plc_pkg::CMD_RESTART : plc_pkg::CMD_CHECK;
        item_in.word = s_data.data_word & keep_mask[plc_pkg::MAX_WORD_BITS-1:0];
        item_in.count = n_sat;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == plc_pkg::QPTR_W'(plc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == plc_pkg::QPTR_W'(plc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

    assign q_head.valid = (cnt_reg != '0);
    assign q_head.item  = q_mem[rd_ptr_reg];

    `PLC_ASSERT(a_cnt_bound, cnt_reg <= plc_pkg::QCNT_W'(plc_pkg::QUEUE_DEPTH))
    `PLC_ASSERT(a_pop_nonempty, q_pop |-> (cnt_reg != '0))

endmodule

`default_nettype wire

>>> rtl/core/plc_back.sv
`default_nettype none
`include "assert_macros.svh"

module plc_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire plc_pkg::cfg_t    cfg,
    input  wire plc_pkg::q_head_t q_head,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output plc_pkg::out_t         m_data
);

    plc_pkg::phase_t                   phase_reg, phase_next;
    logic [plc_pkg::HIST_W-1:0]        history_reg, history_next;
    logic [plc_pkg::THR_W-1:0]         run_reg, run_next;
    logic [plc_pkg::TOTAL_W-1:0]       bit_total_reg, bit_total_next;
    logic [plc_pkg::TOTAL_W-1:0]       err_total_reg, err_total_next;
    logic [plc_pkg::LOCKS_W-1:0]       lock_total_reg, lock_total_next;
    logic                              lock_flag_reg, lock_flag_next;

    // multi-cycle walk through one word
    logic                              started_reg, started_next;
    logic [plc_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [plc_pkg::MAX_WORD_BITS-1:0] wrk_reg, wrk_next;
    logic [plc_pkg::CNT_W-1:0]         errs_acc_reg, errs_acc_next;

    logic                              out_valid_reg, out_valid_next;
    plc_pkg::out_t                     out_reg, out_next;

    plc_pkg::item_t                    item;
    plc_pkg::chunk_res_t               chunk;
    logic [plc_pkg::MAX_WORD_BITS-1:0] aligned, cur_word;
    logic [plc_pkg::CNT_W-1:0]         cur_rem, errs_all;
    logic [plc_pkg::CHUNK_CNT_W-1:0]   k;
    logic                              is_check, last, out_free, go;
    logic [plc_pkg::TOTAL_W-1:0]       bit_sum, err_sum;
    logic [plc_pkg::THR_W:0]           run_sum;
    logic [plc_pkg::THR_W-1:0]         run_cand;

    always_comb begin
        item     = q_head.item;
        aligned  = item.word << (plc_pkg::CNT_W'(plc_pkg::MAX_WORD_BITS) - item.count);
        cur_rem  = started_reg ? rem_reg : item.count;
        cur_word = started_reg ? wrk_reg : aligned;
        is_check = (item.cmd == plc_pkg::CMD_CHECK) && (phase_reg != plc_pkg::PH_SEED);
        last     = !is_check || (cur_rem <= plc_pkg::CNT_W'(plc_pkg::CHUNK_BITS));
        k        = (cur_rem > plc_pkg::CNT_W'(plc_pkg::CHUNK_BITS))
                 ? plc_pkg::CHUNK_CNT_W'(plc_pkg::CHUNK_BITS)
                 : cur_rem[plc_pkg::CHUNK_CNT_W-1:0];
        chunk    = plc_pkg::lfsr_chunk(history_reg, cfg.tap_mask, cfg.invert_output,
                       cur_word[plc_pkg::MAX_WORD_BITS-1 -: plc_pkg::CHUNK_BITS], k);
        errs_all = errs_acc_reg + plc_pkg::CNT_W'(chunk.errs);
        out_free = !out_valid_reg || m_ready;
        go       = q_head.valid && (!last || out_free);
        q_pop    = q_head.valid && last && out_free;

        bit_sum  = bit_total_reg + plc_pkg::TOTAL_W'(item.count);
        err_sum  = err_total_reg + plc_pkg::TOTAL_W'(errs_all);
        run_sum  = {1'b0, run_reg} + (plc_pkg::THR_W + 1)'(item.count);
        run_cand = run_sum[plc_pkg::THR_W] ? '1 : run_sum[plc_pkg::THR_W-1:0];
    end

    // next state and status
    always_comb begin
        phase_next      = phase_reg;
        history_next    = history_reg;
        run_next        = run_reg;
        bit_total_next  = bit_total_reg;
        err_total_next  = err_total_reg;
        lock_total_next = lock_total_reg;
        lock_flag_next  = lock_flag_reg;
        started_next    = started_reg;
        rem_next        = rem_reg;
        wrk_next        = wrk_reg;
        errs_acc_next   = errs_acc_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;

        if (go && !last) begin
            started_next  = 1'b1;
            rem_next      = cur_rem - plc_pkg::CNT_W'(plc_pkg::CHUNK_BITS);
            wrk_next      = cur_word << plc_pkg::CHUNK_BITS;
            history_next  = chunk.hist;
            errs_acc_next = errs_all;
        end else if (go) begin
            started_next   = 1'b0;
            errs_acc_next  = '0;
            out_valid_next = 1'b1;
            if (item.cmd == plc_pkg::CMD_RESTART) begin
                bit_total_next  = '0;
                err_total_next  = '0;
                lock_total_next = '0;
                lock_flag_next  = 1'b0;
                run_next        = '0;
                phase_next      = plc_pkg::PH_SEED;
            end else begin
                case (phase_reg)
                    plc_pkg::PH_LOCKING: begin
                        history_next   = chunk.hist;
                        bit_total_next = bit_sum;
                        if (errs_all != '0) begin
                            err_total_next = err_sum;
                            run_next       = '0;
                        end else begin
                            run_next = run_cand;
                        end
                        if (run_next >= cfg.lock_threshold) begin
                            lock_flag_next  = 1'b1;
                            lock_total_next = lock_total_reg + 1'b1;
                            phase_next      = plc_pkg::PH_LOCKED;
                        end
                    end
                    plc_pkg::PH_LOCKED: begin
                        history_next   = chunk.hist;
                        bit_total_next = bit_sum;
                        err_total_next = err_sum;
                        if (err_sum >= plc_pkg::TOTAL_W'(cfg.unlock_threshold)) begin
                            bit_total_next = '0;
                            err_total_next = '0;
                            lock_flag_next = 1'b0;
                            phase_next     = plc_pkg::PH_LOCKING;
                        end
                    end
                    default: begin
                        // seeding: raw bits go straight into the history
                        history_next   = (history_reg << item.count) | item.word;
                        bit_total_next = bit_sum;
                        if (bit_sum >= plc_pkg::TOTAL_W'(cfg.poly_order)) begin
                            phase_next = plc_pkg::PH_LOCKING;
                        end
                    end
                endcase
            end
            out_next.locked      = lock_flag_next;
            out_next.seeding     = (phase_next == plc_pkg::PH_SEED);
            out_next.total_bits  = bit_total_next;
            out_next.error_bits  = err_total_next;
            out_next.lock_events = lock_total_next;
            out_next.word_errors = is_check ? errs_all : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= plc_pkg::PH_SEED;
            history_reg    <= '0;
            run_reg        <= '0;
            bit_total_reg  <= '0;
            err_total_reg  <= '0;
            lock_total_reg <= '0;
            lock_flag_reg  <= 1'b0;
            started_reg    <= 1'b0;
            rem_reg        <= '0;
            errs_acc_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            history_reg    <= history_next;
            run_reg        <= run_next;
            bit_total_reg  <= bit_total_next;
            err_total_reg  <= err_total_next;
            lock_total_reg <= lock_total_next;
            lock_flag_reg  <= lock_flag_next;
            started_reg    <= started_next;
            rem_reg        <= rem_next;
            errs_acc_reg   <= errs_acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wrk_reg <= wrk_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `PLC_ASSERT(a_started_head, started_reg |-> q_head.valid)
    `PLC_ASSERT(a_started_rem, started_reg |-> (rem_reg != '0))
    `PLC_ASSERT(a_seed_no_err, (out_valid_reg && out_reg.seeding) |-> (out_reg.word_errors == '0))

endmodule

`default_nettype wire

>>> rtl/core/prbs_lock_checker.sv
// Self-synchronizing PRBS checker. Words of 0 to 32 bits (oldest bit highest)
// enter on s_; larger bit counts are clamped to 32. Restart words and words taken
// while seeding bypass the LFSR. The back end's LFSR unit takes check words in
// chunks of up to 8 bits per cycle and holds the last chunk for a free result
// register. Words of up to 8 bits thus run at one per cycle while that register
// is free. A 4-entry queue sits between the input classifier and the back end;
// one result register holds the status. m_valid comes from that register. The
// user must write configuration through cfg_wr_en, cfg_index and cfg_wr_data
// only while no transaction is in flight; the block does not enforce this.
`default_nettype none

module prbs_lock_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire plc_pkg::in_t                     s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output plc_pkg::out_t                         m_data,
    input  wire logic                             cfg_wr_en,
    input  wire logic [plc_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [plc_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    plc_pkg::cfg_t    cfg_reg, cfg_next;
    plc_pkg::q_head_t q_head;
    logic             q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                plc_pkg::REG_LOCK_THR:   cfg_next.lock_threshold   = cfg_wr_data;
                plc_pkg::REG_UNLOCK_THR: cfg_next.unlock_threshold = cfg_wr_data;
                plc_pkg::REG_TAP_MASK:   cfg_next.tap_mask         = cfg_wr_data;
                plc_pkg::REG_POLY_ORDER: begin
                    cfg_next.poly_order = cfg_wr_data[plc_pkg::ORDER_W-1:0];
                end
                plc_pkg::REG_INVERT:     cfg_next.invert_output    = cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lock_threshold   <= plc_pkg::LOCK_THR_RST;
            cfg_reg.unlock_threshold <= plc_pkg::UNLOCK_THR_RST;
            cfg_reg.tap_mask         <= plc_pkg::TAP_MASK_RST;
            cfg_reg.poly_order       <= plc_pkg::POLY_ORDER_RST;
            cfg_reg.invert_output    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    plc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    plc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
